// ===== src/stkb_pkg.sv =====
// Shared constants, types and codes of the spectrum-to-key binner.
package stkb_pkg;

    localparam int NUM_KEYS  = 88;
    localparam int FRAC_BITS = 8;

    localparam int KEY_W     = 7;
    localparam int POS_W     = 16;
    localparam int AMP_W     = 16;
    localparam int TOTAL_W   = 20;
    localparam int WSUM_W    = 40;
    localparam int WGT_SUM_W = 24;
    localparam int CMD_W     = 2;

    localparam int ONE_Q      = 1 << FRAC_BITS;
    localparam int HALF_Q     = 1 << (FRAC_BITS - 1);
    localparam int SHIFT_Q    = (ONE_Q + 50) / 100;
    localparam int WEIGHT_TOP = ONE_Q + SHIFT_Q;
    localparam int WGT_W      = FRAC_BITS + 1;
    localparam int PROD_W     = AMP_W + WGT_W;
    localparam int KFULL_W    = POS_W - FRAC_BITS;

    // The average of one key never exceeds 2^16, so 18 quotient bits suffice.
    localparam int QUOT_W        = 18;
    localparam int DIV_BITS      = 2;
    localparam int DIV_CYCLES    = QUOT_W / DIV_BITS;
    localparam int DIV_CNT_W     = 4;
    localparam int DIV_HIGH_W    = WSUM_W - QUOT_W;

    // Stream packing, lowest field first.
    localparam int POS_LSB       = 0;
    localparam int AMP_LSB       = POS_LSB + POS_W;
    localparam int IDX_LSB       = AMP_LSB + AMP_W;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 24;

    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_W    = 1;
    localparam int FIFO_CNT_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_BIN   = 2'd0,
        CMD_FLUSH = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // One classified command as it travels from the front to the back.
    typedef struct packed {
        cmd_t               cmd;
        logic [KEY_W-1:0]   key;
        logic               key_ok;
        logic [AMP_W-1:0]   amp;
        logic [WGT_W-1:0]   weight;
    } item_t;

endpackage

// ===== src/stkb_front.sv =====
// Front end: accepts stream transfers, finds the nearest key and weight of each bin.
module stkb_front (
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [stkb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [stkb_pkg::CMD_W-1:0]         s_axis_tuser,
    input  logic                               fifo_full,
    output logic                               push,
    output stkb_pkg::item_t                    push_item
);

    logic [stkb_pkg::POS_W-1:0]     key_pos;
    logic [stkb_pkg::AMP_W-1:0]     amplitude;
    logic [stkb_pkg::KEY_W-1:0]     key_index;
    logic [stkb_pkg::POS_W:0]       pos_biased;
    logic [stkb_pkg::KFULL_W-1:0]   key_full;
    logic [stkb_pkg::FRAC_BITS-1:0] frac;
    logic [stkb_pkg::FRAC_BITS-1:0] off_abs;
    logic                           bin_on_board;
    logic                           index_ok;
    stkb_pkg::cmd_t                 cmd;

    assign key_pos   = s_axis_tdata[stkb_pkg::POS_LSB +: stkb_pkg::POS_W];
    assign amplitude = s_axis_tdata[stkb_pkg::AMP_LSB +: stkb_pkg::AMP_W];
    assign key_index = s_axis_tdata[stkb_pkg::IDX_LSB +: stkb_pkg::KEY_W];
    assign cmd       = stkb_pkg::cmd_t'(s_axis_tuser);

    // Adding half a key and truncating gives the nearest key; the low bits give the offset.
    assign pos_biased = {key_pos[stkb_pkg::POS_W-1], key_pos}
                      + (stkb_pkg::POS_W + 1)'(stkb_pkg::HALF_Q);
    assign key_full   = pos_biased[stkb_pkg::POS_W-1:stkb_pkg::FRAC_BITS];
    assign frac       = pos_biased[stkb_pkg::FRAC_BITS-1:0];
    assign off_abs    = (frac >= stkb_pkg::FRAC_BITS'(stkb_pkg::HALF_Q))
                      ? frac - stkb_pkg::FRAC_BITS'(stkb_pkg::HALF_Q)
                      : stkb_pkg::FRAC_BITS'(stkb_pkg::HALF_Q) - frac;

    assign bin_on_board = !pos_biased[stkb_pkg::POS_W]
                        && (32'(key_full) < stkb_pkg::NUM_KEYS);
    assign index_ok     = 32'(key_index) < stkb_pkg::NUM_KEYS;

    assign s_axis_tready = !fifo_full;

    always_comb
    begin
        push_item.cmd    = cmd;
        push_item.amp    = amplitude;
        push_item.weight = stkb_pkg::WGT_W'(stkb_pkg::WEIGHT_TOP) - {off_abs, 1'b0};
        push_item.key    = '0;
        push_item.key_ok = 1'b0;
        push             = s_axis_tvalid && s_axis_tready;
        unique case (cmd)
            stkb_pkg::CMD_BIN:
            begin
                push_item.key    = stkb_pkg::KEY_W'(key_full);
                push_item.key_ok = bin_on_board;
                // Bins off the keyboard are dropped here and never reach the back end.
                push             = s_axis_tvalid && s_axis_tready && bin_on_board;
            end
            stkb_pkg::CMD_READ:
            begin
                push_item.key    = index_ok ? key_index : '0;
                push_item.key_ok = index_ok;
            end
            stkb_pkg::CMD_FLUSH,
            stkb_pkg::CMD_CLEAR:
            begin
                push_item.key    = '0;
                push_item.key_ok = 1'b0;
            end
            default:
            begin
                push_item.key    = '0;
                push_item.key_ok = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/stkb_fifo.sv =====
// Short queue of classified commands between the front and back ends.
module stkb_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stkb_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output stkb_pkg::item_t  head_item
);

    stkb_pkg::item_t                 slot_reg [stkb_pkg::FIFO_DEPTH];
    logic [stkb_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [stkb_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [stkb_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full       = count_reg == stkb_pkg::FIFO_CNT_W'(stkb_pkg::FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/stkb_back.sv =====
// Back end: key accumulation, averaging divider, key total memory and read-out register.
module stkb_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  stkb_pkg::item_t                     head_item,
    output logic                                pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [stkb_pkg::TOTAL_W-1:0]        key_total
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic                                pend_valid_reg, pend_valid_next;
    logic [stkb_pkg::KEY_W-1:0]          pend_key_reg, pend_key_next;
    logic [stkb_pkg::WSUM_W-1:0]         wsum_reg, wsum_next;
    logic [stkb_pkg::WGT_SUM_W-1:0]      wtsum_reg, wtsum_next;
    logic [stkb_pkg::WGT_SUM_W-1:0]      rem_reg, rem_next;
    logic [stkb_pkg::QUOT_W-1:0]         quo_reg, quo_next;
    logic [stkb_pkg::DIV_CNT_W-1:0]      div_cnt_reg, div_cnt_next;
    logic                                pop_after_reg, pop_after_next;
    logic [stkb_pkg::NUM_KEYS-1:0]       key_valid_reg, key_valid_next;
    logic                                out_valid_reg, out_valid_next;
    logic [stkb_pkg::TOTAL_W-1:0]        out_data_reg, out_data_next;

    logic [stkb_pkg::TOTAL_W-1:0]        total_mem [stkb_pkg::NUM_KEYS];
    logic [stkb_pkg::TOTAL_W-1:0]        rd_data_reg;
    logic                                rd_valid_reg;
    logic [stkb_pkg::KEY_W-1:0]          rd_addr;
    logic                                mem_we;
    logic [stkb_pkg::TOTAL_W-1:0]        mem_wdata;

    logic [stkb_pkg::PROD_W-1:0]         prod;
    logic [stkb_pkg::WSUM_W:0]           wsum_add;
    logic [stkb_pkg::WGT_SUM_W:0]        wtsum_add;
    logic [stkb_pkg::WGT_SUM_W-1:0]      step_rem;
    logic [stkb_pkg::QUOT_W-1:0]         step_quo;
    logic [stkb_pkg::WGT_SUM_W:0]        trial;
    logic [stkb_pkg::TOTAL_W:0]          total_sum;
    logic                                out_free;
    logic                                need_divide;

    assign m_axis_tvalid = out_valid_reg;
    assign key_total     = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign prod      = head_item.amp * head_item.weight;
    assign wsum_add  = {1'b0, wsum_reg} + (stkb_pkg::WSUM_W + 1)'(prod);
    assign wtsum_add = {1'b0, wtsum_reg} + (stkb_pkg::WGT_SUM_W + 1)'(head_item.weight);
    assign need_divide = pend_valid_reg && (wsum_reg != '0) && (wtsum_reg != '0);

    // Restoring division, two quotient bits per cycle; dividend bits shift out as
    // quotient bits shift in.
    always_comb
    begin
        step_rem = rem_reg;
        step_quo = quo_reg;
        trial    = '0;
        for (int i = 0; i < stkb_pkg::DIV_BITS; i++)
        begin
            trial = {step_rem, step_quo[stkb_pkg::QUOT_W-1]};
            if (trial >= {1'b0, wtsum_reg})
            begin
                trial    = trial - {1'b0, wtsum_reg};
                step_quo = {step_quo[stkb_pkg::QUOT_W-2:0], 1'b1};
            end
            else
            begin
                step_quo = {step_quo[stkb_pkg::QUOT_W-2:0], 1'b0};
            end
            step_rem = trial[stkb_pkg::WGT_SUM_W-1:0];
        end
    end

    assign total_sum = {1'b0, (rd_valid_reg ? rd_data_reg : '0)}
                     + (stkb_pkg::TOTAL_W + 1)'(quo_reg);
    assign mem_wdata = total_sum[stkb_pkg::TOTAL_W] ? '1 : total_sum[stkb_pkg::TOTAL_W-1:0];
    assign mem_we    = state_reg == ST_WRITE;

    assign rd_addr = (head_valid && head_item.cmd == stkb_pkg::CMD_READ)
                   ? head_item.key : pend_key_reg;

    always_comb
    begin
        state_next      = state_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        wsum_next       = wsum_reg;
        wtsum_next      = wtsum_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        pop_after_next  = pop_after_reg;
        key_valid_next  = key_valid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        pop             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    unique case (head_item.cmd)
                        stkb_pkg::CMD_BIN:
                        begin
                            if (!pend_valid_reg || pend_key_reg == head_item.key)
                            begin
                                pend_valid_next = 1'b1;
                                pend_key_next   = head_item.key;
                                wsum_next  = wsum_add[stkb_pkg::WSUM_W] ? '1
                                           : wsum_add[stkb_pkg::WSUM_W-1:0];
                                wtsum_next = wtsum_add[stkb_pkg::WGT_SUM_W] ? '1
                                           : wtsum_add[stkb_pkg::WGT_SUM_W-1:0];
                                pop = 1'b1;
                            end
                            else
                            begin
                                // A new key: close out the pending one, then retake this bin.
                                pop_after_next = 1'b0;
                                if (need_divide)
                                begin
                                    state_next = ST_DIV;
                                end
                                else
                                begin
                                    pend_valid_next = 1'b0;
                                    pend_key_next   = '0;
                                    wsum_next       = '0;
                                    wtsum_next      = '0;
                                end
                            end
                        end
                        stkb_pkg::CMD_FLUSH:
                        begin
                            pop_after_next = 1'b1;
                            if (need_divide)
                            begin
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                pend_valid_next = 1'b0;
                                pend_key_next   = '0;
                                wsum_next       = '0;
                                wtsum_next      = '0;
                                pop             = 1'b1;
                            end
                        end
                        stkb_pkg::CMD_READ:
                        begin
                            state_next = ST_READ;
                        end
                        stkb_pkg::CMD_CLEAR:
                        begin
                            key_valid_next  = '0;
                            pend_valid_next = 1'b0;
                            pend_key_next   = '0;
                            wsum_next       = '0;
                            wtsum_next      = '0;
                            pop             = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                    rem_next     = stkb_pkg::WGT_SUM_W'(wsum_reg[stkb_pkg::WSUM_W-1:stkb_pkg::QUOT_W]);
                    quo_next     = wsum_reg[stkb_pkg::QUOT_W-1:0];
                    div_cnt_next = '0;
                end
            end
            ST_DIV:
            begin
                rem_next     = step_rem;
                quo_next     = step_quo;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == stkb_pkg::DIV_CNT_W'(stkb_pkg::DIV_CYCLES - 1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                key_valid_next[pend_key_reg] = 1'b1;
                pend_valid_next = 1'b0;
                pend_key_next   = '0;
                wsum_next       = '0;
                wtsum_next      = '0;
                pop             = pop_after_reg;
                state_next      = ST_IDLE;
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = (rd_valid_reg && head_item.key_ok) ? rd_data_reg : '0;
                    pop            = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            pend_key_reg   <= '0;
            wsum_reg       <= '0;
            wtsum_reg      <= '0;
            div_cnt_reg    <= '0;
            pop_after_reg  <= 1'b0;
            key_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            pend_key_reg   <= pend_key_next;
            wsum_reg       <= wsum_next;
            wtsum_reg      <= wtsum_next;
            div_cnt_reg    <= div_cnt_next;
            pop_after_reg  <= pop_after_next;
            key_valid_reg  <= key_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
    end

    // Key total memory: one write port, one registered read port, read only while idle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            total_mem[pend_key_reg] <= mem_wdata;
        end
        if (state_reg == ST_IDLE)
        begin
            rd_data_reg  <= total_mem[rd_addr];
            rd_valid_reg <= key_valid_reg[rd_addr];
        end
    end

endmodule

// ===== src/spectrum_to_key_binner_unit.sv =====
// Top level of the spectrum-to-key binner: front end, command queue and back end.
//
// Commands arrive on the s_axis channel, one per transfer; the command code rides in
// s_axis_tuser. Bin commands carry a key position and amplitude, read commands a key
// index. Only a read produces a result, a key total on the m_axis channel.
// The front end classifies each command combinationally and places it in a two-entry
// queue; bins off the keyboard are dropped there. s_axis_tready is low only while the
// queue is full.
// The back end takes one bin per cycle while the key stays the same. A change of key or
// a flush runs the average divider when the pending key has nonzero sums; the divider
// retires two quotient bits per cycle, and then the key total memory is updated. A bin
// that changed the key is then taken again. A read goes through the registered memory
// read and the output register. A clear drops all key totals and the pending sums.
// A read result sits in an output register; if the receiver stalls, the queue keeps
// taking commands until a second read would overwrite it; the back end then waits and the queue fills.
// Reset clears all key totals through per-key valid bits, so the block accepts
// commands as soon as reset is released.
module spectrum_to_key_binner_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // key_pos[15:0], amplitude[31:16], key_index[38:32], zero[39]
    input  logic [stkb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd[1:0]
    input  logic [stkb_pkg::CMD_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // key_total[19:0], zero[23:20]
    output logic [stkb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic                         push;
    stkb_pkg::item_t              push_item;
    logic                         fifo_full;
    logic                         pop;
    logic                         head_valid;
    stkb_pkg::item_t              head_item;
    logic [stkb_pkg::TOTAL_W-1:0] key_total;

    stkb_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_item     (push_item)
    );

    stkb_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    stkb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .key_total     (key_total)
    );

    assign m_axis_tdata = stkb_pkg::OUT_TDATA_W'(key_total);

endmodule
